FILE: hdl/sensor_alarm_with_code_unlock_unit_defines.svh
// ----------------------------------------------------------------------------
// Sensor alarm assertion macros
// Shared concurrent assertion forms for the sensor alarm block.
// ----------------------------------------------------------------------------
`ifndef SENSOR_ALARM_WITH_CODE_UNLOCK_UNIT_DEFINES_SVH
`define SENSOR_ALARM_WITH_CODE_UNLOCK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SAR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sar_pkg.sv
// ----------------------------------------------------------------------------
// Sensor alarm package
// Sizes, codes and shared types of the sensor alarm with code unlock.
// ----------------------------------------------------------------------------
package sar_pkg;

  // Sample window and code entry sizes.
  localparam int WINDOW    = 100;
  localparam int CODE_KEYS = 5;

  localparam int SAMPLE_W   = 12;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int SUM_W      = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int KEY_W      = 4;
  localparam int CNT_W      = $clog2(CODE_KEYS + 1);
  localparam int KIDX_W     = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1;

  // Port field widths.
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int TOTAL_W     = 19;
  localparam int COUNT_OUT_W = 3;
  localparam int EV_W        = 3;

  // Register reset values.
  localparam logic [CFG_W-1:0] TEMP_LIMIT_RESET  = 20'd34745;
  localparam logic [CFG_W-1:0] UNLOCK_CODE_RESET = 20'h54321;

  // Special keys.
  localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd14;
  localparam logic [KEY_W-1:0] KEY_ENTER = 4'd15;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_LIMIT  = 2'd0,
    REG_UNLOCK_CODE = 2'd1
  } cfg_reg_t;

  // Event codes reported with each result.
  typedef enum logic [EV_W-1:0] {
    EV_NONE     = 3'd0,
    EV_RAISED   = 3'd1,
    EV_KEY      = 3'd2,
    EV_CLEARED  = 3'd3,
    EV_WRONG    = 3'd4,
    EV_UNLOCKED = 3'd5
  } event_t;

  // Window stage results for the item being processed.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             hot;
  } win_t;

  // Alarm and code entry results for the item being processed.
  typedef struct packed {
    logic             alarm;
    logic [CNT_W-1:0] count;
    event_t           ev;
  } ctrl_t;

endpackage

FILE: hdl/sar_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic             re;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/sar_window.sv
// ----------------------------------------------------------------------------
// Sample window
// Ring of temperature samples with a running sum and over-limit compare.
// ----------------------------------------------------------------------------
module sar_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [sar_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          advance,
  input  logic [sar_pkg::CFG_W-1:0]     limit,
  output sar_pkg::win_t                 win
);
  import sar_pkg::*;

  localparam int CMP_W = (SUM_W > CFG_W) ? SUM_W : CFG_W;

  logic [POS_W-1:0]    pos;
  logic                wrapped;
  logic                primed;
  logic [SAMPLE_W-1:0] first_sample;

  logic [SAMPLE_W-1:0] s1_sample;
  logic [POS_W-1:0]    s1_pos;
  logic                s1_first;
  logic                s1_wrapped;
  logic                fwd_hit;
  logic [SAMPLE_W-1:0] fwd_data;

  logic [SAMPLE_W-1:0] ram_q;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;

  // Ring storage, read at transfer time and written back when the item retires.
  sar_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (advance),
    .waddr(s1_pos),
    .wdata(s1_sample),
    .re   (accept),
    .raddr(pos),
    .rdata(ram_q)
  );

  // Input side: ring position, lap flag and the priming sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      wrapped <= 1'b0;
      primed  <= 1'b0;
    end else if (accept) begin
      primed <= 1'b1;
      if (pos == POS_W'(WINDOW - 1)) begin
        pos     <= '0;
        wrapped <= 1'b1;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  // Item held for processing, with a bypass for a write to the address being read.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!primed) begin
        first_sample <= sample;
      end
      s1_sample  <= sample;
      s1_pos     <= pos;
      s1_first   <= !primed;
      s1_wrapped <= wrapped;
      fwd_hit    <= advance && (s1_pos == pos);
      fwd_data   <= s1_sample;
    end
  end

  // Entries not yet written in the first lap still hold the priming sample.
  always_comb begin
    if (s1_first) begin
      old_sample = s1_sample;
    end else if (!s1_wrapped) begin
      old_sample = first_sample;
    end else if (fwd_hit) begin
      old_sample = fwd_data;
    end else begin
      old_sample = ram_q;
    end
  end

  // Running sum update; the first item fills the whole window.
  always_comb begin
    if (s1_first) begin
      sum_next = SUM_W'(WINDOW) * SUM_W'(s1_sample);
    end else begin
      sum_next = sum - SUM_W'(old_sample) + SUM_W'(s1_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (advance) begin
      sum <= sum_next;
    end
  end

  assign win.sum = sum_next;
  assign win.hot = CMP_W'(sum_next) > CMP_W'(limit);

endmodule

FILE: hdl/sar_ctrl.sv
// ----------------------------------------------------------------------------
// Alarm control
// Alarm latch and keypad code entry with unlock check.
// ----------------------------------------------------------------------------
module sar_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        hot,
  input  logic                        gas,
  input  logic                        key_valid,
  input  logic [sar_pkg::KEY_W-1:0]   key_code,
  input  logic [sar_pkg::CFG_W-1:0]   unlock_code,
  output sar_pkg::ctrl_t              nxt
);
  import sar_pkg::*;

  localparam int CODE_BITS = CODE_KEYS * KEY_W;

  logic                 alarm;
  logic [CNT_W-1:0]     count;
  logic [KEY_W-1:0]     keys [CODE_KEYS];

  logic                 raise;
  logic                 alarm_v;
  logic [CNT_W-1:0]     cnt_v;
  logic [CODE_BITS-1:0] want;
  logic                 match;
  logic                 key_we;
  logic [KIDX_W-1:0]    key_idx;

  // Expected keys; positions beyond the register compare against zero.
  assign want = CODE_BITS'(unlock_code);

  // Alarm raise comes first and empties the entry.
  assign raise   = (gas || hot) && !alarm;
  assign alarm_v = alarm || raise;
  assign cnt_v   = raise ? '0 : count;
  assign key_idx = cnt_v[KIDX_W-1:0];

  // Full entry compare, one key per position.
  always_comb begin
    match = (cnt_v == CNT_W'(CODE_KEYS));
    for (int i = 0; i < CODE_KEYS; i++) begin
      if (keys[i] != want[i*KEY_W +: KEY_W]) begin
        match = 1'b0;
      end
    end
  end

  // Key handling while the alarm is active.
  always_comb begin
    nxt.alarm = alarm_v;
    nxt.count = cnt_v;
    nxt.ev    = raise ? EV_RAISED : EV_NONE;
    key_we    = 1'b0;
    if (key_valid && alarm_v) begin
      case (key_code)
        KEY_ENTER: begin
          nxt.count = '0;
          if (match) begin
            nxt.alarm = 1'b0;
            nxt.ev    = EV_UNLOCKED;
          end else begin
            nxt.ev = EV_WRONG;
          end
        end
        KEY_CLEAR: begin
          nxt.count = '0;
          nxt.ev    = EV_CLEARED;
        end
        default: begin
          if (cnt_v < CNT_W'(CODE_KEYS)) begin
            key_we    = 1'b1;
            nxt.count = cnt_v + CNT_W'(1);
            nxt.ev    = EV_KEY;
          end
        end
      endcase
    end
  end

  // State update when the item retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm <= 1'b0;
      count <= '0;
    end else if (advance) begin
      alarm <= nxt.alarm;
      count <= nxt.count;
    end
  end

  // Entered keys need no reset: they are compared only once the entry is full.
  always_ff @(posedge clk) begin
    if (advance && key_we) begin
      keys[key_idx] <= key_code;
    end
  end

endmodule

FILE: hdl/sensor_alarm_with_code_unlock_unit.sv
// An input transfer is held in the processing stage and then written to the result
// register once that register is free. Throughput: one tick per cycle while result_stall
// does not hold the output, set by one read and one write of the sample ring RAM.
// Reset: synchronous, clears position, sum, alarm and entry count; registers return to
// their defaults. The ring RAM is not cleared: entries not yet written in the first
// lap read as the priming sample, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Sensor alarm with code unlock
// Gas and temperature alarm with a moving-average window and keypad unlock.
// ----------------------------------------------------------------------------
`include "sensor_alarm_with_code_unlock_unit_defines.svh"

module sensor_alarm_with_code_unlock_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [sar_pkg::SAMPLE_W-1:0]     temp_sample,
  input  logic                             gas_detected,
  input  logic                             key_valid,
  input  logic [sar_pkg::KEY_W-1:0]        key_code,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             buzzer_on,
  output logic                             alarm_latched,
  output logic                             warn_gas,
  output logic                             warn_temp,
  output logic [sar_pkg::COUNT_OUT_W-1:0]  keys_entered,
  output logic [sar_pkg::EV_W-1:0]         event_res,
  output logic [sar_pkg::TOTAL_W-1:0]      window_total,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sar_pkg::CFG_W-1:0]        cfg_data
);
  import sar_pkg::*;

  logic [CFG_W-1:0] temp_limit_sum;
  logic [CFG_W-1:0] unlock_code;

  logic             accept;
  logic             advance;
  logic             s1_valid;
  logic             s1_gas;
  logic             s1_kv;
  logic [KEY_W-1:0] s1_key;

  win_t             win;
  ctrl_t            nxt;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_limit_sum <= TEMP_LIMIT_RESET;
      unlock_code    <= UNLOCK_CODE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP_LIMIT:  temp_limit_sum <= cfg_data;
        REG_UNLOCK_CODE: unlock_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the processing stage retires when the result register is free.
  assign advance      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !advance;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gas <= gas_detected;
      s1_kv  <= key_valid;
      s1_key <= key_code;
    end
  end

  // Window sum and over-temperature compare.
  sar_window u_window (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (temp_sample),
    .advance(advance),
    .limit  (temp_limit_sum),
    .win    (win)
  );

  // Alarm latch and code entry.
  sar_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .hot        (win.hot),
    .gas        (s1_gas),
    .key_valid  (s1_kv),
    .key_code   (s1_key),
    .unlock_code(unlock_code),
    .nxt        (nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      alarm_latched <= nxt.alarm;
      warn_gas      <= s1_gas;
      warn_temp     <= win.hot;
      keys_entered  <= COUNT_OUT_W'(nxt.count);
      event_res     <= nxt.ev;
      window_total  <= TOTAL_W'(win.sum);
    end
  end

  assign buzzer_on = alarm_latched;

  // Checks on the block's own logic.
  `SAR_ASSERT_IMP(a_stall_only_on_full_output, clk, rst, sample_stall,
                  result_valid && result_stall,
                  "input stalled while the result register could drain")
  `SAR_ASSERT_NEXT(a_retire_gives_result, clk, rst, advance, result_valid,
                   "retired item produced no result")
  `SAR_ASSERT_IMP(a_unlock_clears_alarm, clk, rst,
                  result_valid && (event_res == EV_UNLOCKED), !alarm_latched,
                  "unlock reported with the alarm still latched")
  `SAR_ASSERT_IMP(a_raise_empties_entry, clk, rst,
                  result_valid && (event_res == EV_RAISED),
                  alarm_latched && (keys_entered == '0),
                  "alarm raise left the alarm off or keys entered")

endmodule
